@@ rtl/imhq_pkg.sv @@
// Package: shared types, constants and codes for the indexed min-heap queue.
`default_nettype none
package imhq_pkg;
    localparam int HEAP_SLOTS_DEF  = 128;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int ID_W            = 7;
    localparam int ID_COUNT        = 128;
    localparam int FIELD_W         = 16;
    localparam int OCC_W           = 7;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_EXTRACT = 2'd1,
        FUNC_HALVE   = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IDX_RD,
        S_DECIDE,
        S_EXT_RD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

@@ rtl/imhq_slot_ram.sv @@
// Heap record store: one write port, one registered read port.
`default_nettype none
module imhq_slot_ram #(
    parameter int DEPTH = imhq_pkg::HEAP_SLOTS_DEF,
    parameter int WIDTH = 55
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/imhq_index_ram.sv @@
// Id-to-slot index: valid bit per id in flops, slot numbers in a memory.
`default_nettype none
module imhq_index_ram #(
    parameter int SW = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      we,
    input  wire logic [imhq_pkg::ID_W-1:0] waddr,
    input  wire logic                      wvalid,
    input  wire logic [SW-1:0]             wslot,
    input  wire logic [imhq_pkg::ID_W-1:0] raddr,
    output logic                           rvalid,
    output logic      [SW-1:0]             rslot
);
    logic [SW-1:0]                   mem [imhq_pkg::ID_COUNT];
    logic [imhq_pkg::ID_COUNT-1:0]   valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvalid    <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= wvalid;
            end
            rvalid <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wslot;
        end
        rslot <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/indexed_min_heap_queue.sv @@
// Top level: indexed binary min-heap priority queue of job records.
// Usage:
//  - Input channel (in_valid/in_ready) carries one operation item: func selects
//    insert, extract-minimum or halve-key; job_id and the three length/time
//    fields go with it. func 3 is a no-op that answers ok.
//  - Output channel (out_valid/out_ready) returns exactly one result item per
//    input item: status, the extracted record (zero unless a good extract) and
//    the occupancy after the operation.
//  - One item is worked at a time. Records live in a one-port-read heap RAM
//    and an id index RAM, both with registered reads. Each level of a sift
//    is a read/compare/swap: sift-up reads the parent and compares; sift-down
//    reads the left child, then the right, and compares. Insert writes the
//    record to the new last slot and sifts it up; halve-key first reads and
//    rewrites the record, then sifts it up; extract moves the last record to
//    the root and sifts it down.
//  - The result sits in an output register; a new item is taken once the
//    result is handed over or as it is taken in the same cycle.
//  - Reset clears the count and all id valid bits at once; no clearing pass.
//    A stalled receiver holds the result and blocks further items.
`default_nettype none
module indexed_min_heap_queue #(
    parameter int HEAP_SLOTS  = imhq_pkg::HEAP_SLOTS_DEF,
    parameter int LENGTH_BITS = imhq_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    func,
    input  wire logic [imhq_pkg::ID_W-1:0]     job_id,
    input  wire logic [imhq_pkg::FIELD_W-1:0]  start_time,
    input  wire logic [imhq_pkg::FIELD_W-1:0]  job_length,
    input  wire logic [imhq_pkg::FIELD_W-1:0]  rem_length,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [imhq_pkg::ID_W-1:0]          out_job_id,
    output logic [imhq_pkg::FIELD_W-1:0]       out_start_time,
    output logic [imhq_pkg::FIELD_W-1:0]       out_job_length,
    output logic [imhq_pkg::FIELD_W-1:0]       out_rem_length,
    output logic [imhq_pkg::OCC_W-1:0]         occupancy
);
    localparam int SW = $clog2(HEAP_SLOTS);      // slot address bits
    localparam int CW = SW + 1;                  // count / child index bits
    localparam int LB = LENGTH_BITS;
    localparam int RW = imhq_pkg::ID_W + 3 * LB; // record width
    localparam int FW = imhq_pkg::FIELD_W;

    typedef struct packed {
        logic [imhq_pkg::ID_W-1:0] id;
        logic [LB-1:0]             start;
        logic [LB-1:0]             len;
        logic [LB-1:0]             rem;
    } rec_t;

    function automatic logic before_f(input rec_t a, input rec_t b);
        if (a.rem != b.rem)
        begin
            return a.rem < b.rem;
        end
        return a.id < b.id;
    endfunction

    // ---------------- registers ----------------
    imhq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [1:0]        func_reg, func_next;
    rec_t              in_rec_reg, in_rec_next;
    logic [CW-1:0]     pos_reg, pos_next;      // current slot of moving record
    rec_t              cur_reg, cur_next;      // moving record
    rec_t              best_reg, best_next;    // child candidate
    logic [CW-1:0]     best_pos_reg, best_pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        st_reg, st_next;
    rec_t              got_reg, got_next;

    // ---------------- memories ----------------
    logic              hw_we;
    logic [SW-1:0]     hw_addr, hr_addr;
    rec_t              hw_data;
    logic [RW-1:0]     hr_raw;
    rec_t              hr_data;

    logic                       iw_we, iw_valid;
    logic [imhq_pkg::ID_W-1:0]  iw_addr, ir_addr;
    logic [SW-1:0]              iw_slot, ir_slot;
    logic                       ir_valid;

    imhq_slot_ram #(.DEPTH(HEAP_SLOTS), .WIDTH(RW)) u_slots (
        .clk   (clk),
        .we    (hw_we),
        .waddr (hw_addr),
        .wdata (hw_data),
        .raddr (hr_addr),
        .rdata (hr_raw)
    );
    assign hr_data = rec_t'(hr_raw);

    imhq_index_ram #(.SW(SW)) u_index (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (iw_we),
        .waddr  (iw_addr),
        .wvalid (iw_valid),
        .wslot  (iw_slot),
        .raddr  (ir_addr),
        .rvalid (ir_valid),
        .rslot  (ir_slot)
    );

    logic accept;
    assign in_ready = (state_reg == imhq_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    logic [CW-1:0] par;
    logic [CW-1:0] lchild;
    assign par    = pos_reg >> 1;
    assign lchild = {pos_reg[CW-2:0], 1'b0};

    // better of the two children during sift-down (right only if present)
    logic          dn_right_wins;
    rec_t          dn_best;
    logic [CW-1:0] dn_best_pos;
    assign dn_right_wins = ((lchild + CW'(1)) <= count_reg) && before_f(hr_data, best_reg);
    assign dn_best       = dn_right_wins ? hr_data : best_reg;
    assign dn_best_pos   = dn_right_wins ? (lchild + CW'(1)) : best_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imhq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        in_rec_reg   <= in_rec_next;
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_pos_reg <= best_pos_next;
        st_reg       <= st_next;
        got_reg      <= got_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imhq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = imhq_pkg::S_IDX_RD;
                end
            end
            imhq_pkg::S_IDX_RD:  state_next = imhq_pkg::S_DECIDE;
            imhq_pkg::S_DECIDE:
            begin
                unique case (func_reg)
                    imhq_pkg::FUNC_INSERT:
                    begin
                        if (count_reg >= CW'(HEAP_SLOTS - 1) || ir_valid)
                            state_next = imhq_pkg::S_DONE;
                        else
                            state_next = imhq_pkg::S_UP_RD;
                    end
                    imhq_pkg::FUNC_EXTRACT:
                    begin
                        if (count_reg == '0)
                            state_next = imhq_pkg::S_DONE;
                        else
                            state_next = imhq_pkg::S_EXT_RD;
                    end
                    imhq_pkg::FUNC_HALVE:
                    begin
                        if (!ir_valid)
                            state_next = imhq_pkg::S_DONE;
                        else
                            state_next = imhq_pkg::S_EXT_RD;
                    end
                    default: state_next = imhq_pkg::S_DONE;
                endcase
            end
            imhq_pkg::S_EXT_RD:
            begin
                if (func_reg == imhq_pkg::FUNC_HALVE)
                    state_next = imhq_pkg::S_UP_RD;
                else if (count_reg <= CW'(1))
                    state_next = imhq_pkg::S_DONE;
                else
                    state_next = imhq_pkg::S_DN_RD;
            end
            imhq_pkg::S_UP_RD:
            begin
                if (pos_reg <= CW'(1))
                    state_next = imhq_pkg::S_DONE;
                else
                    state_next = imhq_pkg::S_UP_CMP;
            end
            imhq_pkg::S_UP_CMP:
            begin
                if (before_f(cur_reg, hr_data))
                    state_next = imhq_pkg::S_UP_RD;
                else
                    state_next = imhq_pkg::S_DONE;
            end
            imhq_pkg::S_DN_RD:
            begin
                if (lchild > count_reg)
                    state_next = imhq_pkg::S_DONE;
                else
                    state_next = imhq_pkg::S_DN_RD2;
            end
            imhq_pkg::S_DN_RD2:  state_next = imhq_pkg::S_DN_CMP;
            imhq_pkg::S_DN_CMP:
            begin
                if (before_f(dn_best, cur_reg))
                    state_next = imhq_pkg::S_DN_RD;
                else
                    state_next = imhq_pkg::S_DONE;
            end
            imhq_pkg::S_DONE:    state_next = imhq_pkg::S_IDLE;
            default:             state_next = imhq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next     = count_reg;
        func_next      = func_reg;
        in_rec_next    = in_rec_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_pos_next  = best_pos_reg;
        st_next        = st_reg;
        got_next       = got_reg;
        out_valid_next = out_valid_reg;
        hw_we    = 1'b0;
        hw_addr  = pos_reg[SW-1:0];
        hw_data  = cur_reg;
        hr_addr  = pos_reg[SW-1:0];
        iw_we    = 1'b0;
        iw_addr  = cur_reg.id;
        iw_valid = 1'b1;
        iw_slot  = pos_reg[SW-1:0];
        ir_addr  = in_rec_reg.id;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            imhq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next         = func;
                    in_rec_next.id    = job_id;
                    in_rec_next.start = LB'(start_time);
                    in_rec_next.len   = LB'(job_length);
                    in_rec_next.rem   = LB'(rem_length);
                    st_next           = imhq_pkg::ST_OK;
                    got_next          = '0;
                end
            end
            imhq_pkg::S_IDX_RD:
            begin
                // index read issued; also fetch root for extract
                hr_addr = SW'(1);
            end
            imhq_pkg::S_DECIDE:
            begin
                unique case (func_reg)
                    imhq_pkg::FUNC_INSERT:
                    begin
                        if (count_reg >= CW'(HEAP_SLOTS - 1) || ir_valid)
                        begin
                            st_next = imhq_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            pos_next   = count_reg + CW'(1);
                            cur_next   = in_rec_reg;
                            hw_we      = 1'b1;
                            hw_addr    = SW'(count_reg + CW'(1));
                            hw_data    = in_rec_reg;
                            iw_we      = 1'b1;
                            iw_addr    = in_rec_reg.id;
                            iw_slot    = SW'(count_reg + CW'(1));
                            hr_addr    = SW'((count_reg + CW'(1)) >> 1);
                        end
                    end
                    imhq_pkg::FUNC_EXTRACT:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = imhq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            got_next = hr_data;
                            iw_we    = 1'b1;
                            iw_addr  = hr_data.id;
                            iw_valid = 1'b0;
                            hr_addr  = SW'(count_reg);
                            pos_next = CW'(1);
                        end
                    end
                    imhq_pkg::FUNC_HALVE:
                    begin
                        if (!ir_valid)
                        begin
                            st_next = imhq_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            hr_addr  = ir_slot;
                            pos_next = {1'b0, ir_slot};
                        end
                    end
                    default: ;
                endcase
            end
            imhq_pkg::S_EXT_RD:
            begin
                if (func_reg == imhq_pkg::FUNC_HALVE)
                begin
                    cur_next = hr_data;
                    if (hr_data.rem == hr_data.len)
                        cur_next.len = hr_data.len >> 1;
                    cur_next.rem = hr_data.rem >> 1;
                    hw_we    = 1'b1;
                    hw_data  = cur_next;
                    hr_addr  = SW'(par);
                end
                else
                begin
                    // last record moves to root
                    count_next = count_reg - CW'(1);
                    cur_next   = hr_data;
                    if (count_reg > CW'(1))
                    begin
                        hw_we   = 1'b1;
                        hw_addr = SW'(1);
                        hw_data = hr_data;
                        iw_we   = 1'b1;
                        iw_addr = hr_data.id;
                        iw_slot = SW'(1);
                    end
                end
            end
            imhq_pkg::S_UP_RD:
            begin
                // parent read in flight (issued last cycle); hold address
                hr_addr = SW'(par);
                if (pos_reg <= CW'(1))
                begin
                    // reached the root: settle the moving record there
                    hw_we = 1'b1;
                    iw_we = 1'b1;
                end
            end
            imhq_pkg::S_UP_CMP:
            begin
                if (before_f(cur_reg, hr_data))
                begin
                    // parent moves down into pos, cur goes to parent slot
                    hw_we    = 1'b1;
                    hw_addr  = pos_reg[SW-1:0];
                    hw_data  = hr_data;
                    iw_we    = 1'b1;
                    iw_addr  = hr_data.id;
                    iw_slot  = pos_reg[SW-1:0];
                    pos_next = par;
                    hr_addr  = SW'(par >> 1);
                end
                else
                begin
                    hw_we   = 1'b1;
                    iw_we   = 1'b1;
                end
            end
            imhq_pkg::S_DN_RD:
            begin
                hr_addr = SW'(lchild);
                if (lchild > count_reg)
                begin
                    hw_we = 1'b1;
                    iw_we = 1'b1;
                end
            end
            imhq_pkg::S_DN_RD2:
            begin
                // left child data back; issue right child read
                best_next     = hr_data;
                best_pos_next = lchild;
                hr_addr       = SW'(lchild + CW'(1));
            end
            imhq_pkg::S_DN_CMP:
            begin
                best_next     = dn_best;
                best_pos_next = dn_best_pos;
                if (before_f(dn_best, cur_reg))
                begin
                    hw_we    = 1'b1;
                    hw_addr  = pos_reg[SW-1:0];
                    hw_data  = dn_best;
                    iw_we    = 1'b1;
                    iw_addr  = dn_best.id;
                    iw_slot  = pos_reg[SW-1:0];
                    pos_next = dn_best_pos;
                end
                else
                begin
                    hw_we = 1'b1;
                    iw_we = 1'b1;
                end
            end
            imhq_pkg::S_DONE:
            begin
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = st_reg;
    assign out_job_id     = got_reg.id;
    assign out_start_time = FW'(got_reg.start);
    assign out_job_length = FW'(got_reg.len);
    assign out_rem_length = FW'(got_reg.rem);
    assign occupancy      = imhq_pkg::OCC_W'(count_reg);
endmodule
`default_nettype wire

@@ rtl/imhq_checker.sv @@
// Port-level checker for the indexed min-heap queue, bound to the top level.
`default_nettype none
module imhq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] status,
    input wire logic [6:0] out_job_id,
    input wire logic [6:0] occupancy
);
    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
        else $error("result changed while stalled");

    // No new item while a result is stalled.
    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item taken while result stalled");

    // An item cannot return in the cycle after acceptance.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

    // Non-ok status carries no record id.
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != imhq_pkg::ST_OK |-> out_job_id == 7'd0)
        else $error("record id on failed operation");
endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_job_id (out_job_id),
    .occupancy  (occupancy)
);
`default_nettype wire
